>>> rtl/pdr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdr_pkg: shared types and constants of the page-addressed display RAM
// Command codes, register indexes, stream field layout, sequencer states
// and the status bundle of the shared remainder unit.
// ----------------------------------------------------------------------------
package pdr_pkg;

    // Geometry defaults
    localparam int MAX_COLUMNS_DEF = 128;
    localparam int MAX_PAGES_DEF   = 8;

    // Configuration port
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int COLS_REG_W  = 8;
    localparam int PAGES_REG_W = 4;

    localparam logic [CFG_ADDR_W-1:0]  REG_COLUMN_COUNT = 1'd0;
    localparam logic [CFG_ADDR_W-1:0]  REG_PAGE_COUNT   = 1'd1;
    localparam logic [COLS_REG_W-1:0]  COLUMN_COUNT_RST = 8'd128;
    localparam logic [PAGES_REG_W-1:0] PAGE_COUNT_RST   = 4'd8;

    // Request fields
    localparam int CMD_W     = 2;
    localparam int COLUMN_W  = 8;
    localparam int PAGE_W    = 4;
    localparam int BYTE_W    = 8;
    localparam int TUSER_W   = CMD_W;
    localparam int TDATA_W   = 24;
    localparam int COLUMN_LO = 0;
    localparam int PAGE_LO   = COLUMN_LO + COLUMN_W;
    localparam int WBYTE_LO  = PAGE_LO + PAGE_W;

    // Remainder unit: dividend covers an 8-bit column, a 4-bit page and
    // a column pointer plus one up to 256
    localparam int DIV_BITS  = 9;
    localparam int DIV_CNT_W = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET_POS = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_READ    = 2'd2,
        CMD_CLEAR   = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_COL_GO,
        S_COL_WAIT,
        S_PG_GO,
        S_PG_WAIT,
        S_RD,
        S_ADV,
        S_ADV_WAIT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage
`default_nettype wire

>>> rtl/pdr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdr_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered under read enable.
// ----------------------------------------------------------------------------
module pdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> rtl/pdr_mod_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdr_mod_unit: bit-serial remainder unit
// Restoring shift-subtract, one dividend bit per cycle, all DIV_BITS bits in turn.
// done pulses for one cycle; the remainder holds until the next start.
// ----------------------------------------------------------------------------
module pdr_mod_unit #(
    parameter int DVW = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [pdr_pkg::DIV_BITS-1:0] i_dividend,
    input  wire logic [DVW-1:0]               i_divisor,
    output pdr_pkg::t_div_stat                o_stat,
    output logic      [DVW-1:0]               o_rem
);

    import pdr_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_BITS-1:0]  r_num;
    logic [DVW-1:0]       r_den;
    logic [DVW-1:0]       r_rem;

    logic [DVW:0]         w_shift;
    logic [DVW-1:0]       n_rem;

    always_comb begin
        w_shift = {r_rem, r_num[DIV_BITS-1]};
        if (w_shift >= {1'b0, r_den}) begin
            n_rem = DVW'(w_shift - {1'b0, r_den});
        end else begin
            n_rem = DVW'(w_shift);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_num <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_num <= {r_num[DIV_BITS-2:0], 1'b0};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;

endmodule
`default_nettype wire

>>> rtl/page_addressed_display_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// page_addressed_display_ram: display RAM of a monochrome page-addressed LCD
// One byte per column and page, pointer commands, write, read and clear.
// ----------------------------------------------------------------------------
// One request at a time; s_axis_tready is high only when the sequencer is
// idle. A write or a read also makes a pass of the remainder unit
// when the column pointer lies beyond a lowered column count and needs a
// real modulo. A set position makes two passes of the bit-serial
// remainder unit, which all modulo work shares. A clear sweeps the store
// one entry per cycle, all 2**(page bits + column bits) entries
// (1024 at the default geometry); the same sweep runs after reset before
// the first request is taken. Config writes are taken at any time. A read
// result sits in an output register, so a stalled m_axis side only holds
// the block when the next read is ready to deliver.
// ----------------------------------------------------------------------------
module page_addressed_display_ram #(
    parameter int MAX_COLUMNS = pdr_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_PAGES   = pdr_pkg::MAX_PAGES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // config
    input  wire logic                           i_cfg_we,
    input  wire logic [pdr_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [pdr_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // requests
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] column, [11:8] page, [19:12] write_byte, [23:20] zero
    input  wire logic [pdr_pkg::TDATA_W-1:0]    s_axis_tdata,
    // [1:0] cmd
    input  wire logic [pdr_pkg::TUSER_W-1:0]    s_axis_tuser,
    // read results
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [7:0] read_byte
    output logic      [pdr_pkg::BYTE_W-1:0]     m_axis_tdata
);

    import pdr_pkg::*;

    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int PW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int AW    = PW + CW;
    localparam int DEPTH = 2 ** AW;
    localparam int DVW   = (MAX_COLUMNS >= MAX_PAGES) ? $clog2(MAX_COLUMNS + 1)
                                                      : $clog2(MAX_PAGES + 1);

    // state
    t_state               r_state, n_state;
    logic [COLS_REG_W-1:0]  r_cfg_cols;
    logic [PAGES_REG_W-1:0] r_cfg_pages;
    logic [CW-1:0]        r_col_ptr, n_col_ptr;
    logic [PW-1:0]        r_pg_ptr, n_pg_ptr;
    logic [AW-1:0]        r_clr_addr;
    logic [COLUMN_W-1:0]  r_col;
    logic [PAGE_W-1:0]    r_page;
    logic                 r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]    r_out_data;

    // datapath
    t_cmd                 w_cmd;
    logic                 w_accept;
    logic [DVW-1:0]       w_eff_cols;
    logic [DVW-1:0]       w_eff_pages;
    logic [DIV_BITS-1:0]  w_inc;
    logic                 w_slow;
    logic                 w_out_free;
    logic [AW-1:0]        w_ptr_addr;

    // control
    logic                 w_ram_we, w_ram_re, w_clearing;
    logic [AW-1:0]        w_ram_waddr;
    logic [BYTE_W-1:0]    w_ram_wdata, w_ram_rdata;
    logic                 w_div_start;
    logic [DIV_BITS-1:0]  w_dividend;
    logic [DVW-1:0]       w_divisor;
    t_div_stat            w_div_stat;
    logic [DVW-1:0]       w_rem;
    logic                 w_col_ld, w_pg_ld, w_adv_fast, w_adv_slow_ld, w_out_ld;

    assign w_cmd      = t_cmd'(s_axis_tuser[CMD_W-1:0]);
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_ptr_addr = {r_pg_ptr, r_col_ptr};

    // Out-of-range counts fall back to the full geometry
    always_comb begin
        if (r_cfg_cols == '0 || 9'(r_cfg_cols) > 9'(MAX_COLUMNS)) begin
            w_eff_cols = DVW'(MAX_COLUMNS);
        end else begin
            w_eff_cols = DVW'(r_cfg_cols);
        end
        if (r_cfg_pages == '0 || 5'(r_cfg_pages) > 5'(MAX_PAGES)) begin
            w_eff_pages = DVW'(MAX_PAGES);
        end else begin
            w_eff_pages = DVW'(r_cfg_pages);
        end
    end

    // Pointer advance: only a pointer stranded past a lowered count needs the unit
    assign w_inc  = DIV_BITS'(r_col_ptr) + DIV_BITS'(1);
    assign w_slow = w_inc > DIV_BITS'(w_eff_cols);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == '1) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    case (w_cmd)
                        CMD_SET_POS: n_state = S_COL_GO;
                        CMD_WRITE:   n_state = S_ADV;
                        CMD_READ:    n_state = S_RD;
                        CMD_CLEAR:   n_state = S_CLEAR;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_COL_GO:   n_state = S_COL_WAIT;
            S_COL_WAIT: begin
                if (w_div_stat.done) n_state = S_PG_GO;
            end
            S_PG_GO:    n_state = S_PG_WAIT;
            S_PG_WAIT: begin
                if (w_div_stat.done) n_state = S_IDLE;
            end
            S_RD: begin
                if (w_out_free) n_state = S_ADV;
            end
            S_ADV: begin
                n_state = w_slow ? S_ADV_WAIT : S_IDLE;
            end
            S_ADV_WAIT: begin
                if (w_div_stat.done) n_state = S_IDLE;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_axis_tready = 1'b0;
        w_clearing    = 1'b0;
        w_ram_re      = 1'b0;
        w_div_start   = 1'b0;
        w_dividend    = w_inc;
        w_divisor     = w_eff_cols;
        w_col_ld      = 1'b0;
        w_pg_ld       = 1'b0;
        w_adv_fast    = 1'b0;
        w_adv_slow_ld = 1'b0;
        w_out_ld      = 1'b0;
        case (r_state)
            S_CLEAR:    w_clearing = 1'b1;
            S_IDLE: begin
                s_axis_tready = 1'b1;
                w_ram_re      = w_accept && (w_cmd == CMD_READ);
            end
            S_COL_GO: begin
                w_div_start = 1'b1;
                w_dividend  = DIV_BITS'(r_col);
            end
            S_COL_WAIT: w_col_ld = w_div_stat.done;
            S_PG_GO: begin
                w_div_start = 1'b1;
                w_dividend  = DIV_BITS'(r_page);
                w_divisor   = w_eff_pages;
            end
            S_PG_WAIT:  w_pg_ld = w_div_stat.done;
            S_RD:       w_out_ld = w_out_free;
            S_ADV: begin
                w_div_start = w_slow;
                w_adv_fast  = !w_slow;
            end
            S_ADV_WAIT: w_adv_slow_ld = w_div_stat.done;
            default: ;
        endcase
    end

    assign w_ram_we    = w_clearing || (s_axis_tready && w_accept && w_cmd == CMD_WRITE);
    assign w_ram_waddr = w_clearing ? r_clr_addr : w_ptr_addr;
    assign w_ram_wdata = w_clearing ? '0 : s_axis_tdata[WBYTE_LO +: BYTE_W];

    // pointer and output updates
    always_comb begin
        n_col_ptr = r_col_ptr;
        n_pg_ptr  = r_pg_ptr;
        if (w_col_ld || w_adv_slow_ld) begin
            n_col_ptr = CW'(w_rem);
        end else if (w_adv_fast) begin
            n_col_ptr = (w_inc == DIV_BITS'(w_eff_cols)) ? '0 : CW'(w_inc);
        end
        if (w_pg_ld) begin
            n_pg_ptr = PW'(w_rem);
        end
        if (w_out_ld) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cfg_cols  <= COLUMN_COUNT_RST;
            r_cfg_pages <= PAGE_COUNT_RST;
            r_col_ptr   <= '0;
            r_pg_ptr    <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col_ptr   <= n_col_ptr;
            r_pg_ptr    <= n_pg_ptr;
            r_out_valid <= n_out_valid;
            if (w_clearing) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_COLUMN_COUNT: r_cfg_cols  <= i_cfg_wdata[COLS_REG_W-1:0];
                    REG_PAGE_COUNT:   r_cfg_pages <= i_cfg_wdata[PAGES_REG_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_col  <= s_axis_tdata[COLUMN_LO +: COLUMN_W];
            r_page <= s_axis_tdata[PAGE_LO +: PAGE_W];
        end
        if (w_out_ld) begin
            r_out_data <= w_ram_rdata;
        end
    end

    pdr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ptr_addr),
        .o_rdata (w_ram_rdata)
    );

    pdr_mod_unit #(
        .DVW (DVW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_stat     (w_div_stat),
        .o_rem      (w_rem)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
`default_nettype wire

>>> tb/page_addressed_display_ram_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// page_addressed_display_ram_test: self-checking bench for the display RAM
// Requests are queued up front and streamed in with random gaps. A local
// copy of the byte store, pointers and counts predicts every read byte,
// which is checked in order against the result stream under back-pressure.
// ----------------------------------------------------------------------------
module page_addressed_display_ram_test;
    import pdr_pkg::*;

    localparam int COLS          = MAX_COLUMNS_DEF;
    localparam int PAGES         = MAX_PAGES_DEF;
    localparam int SLOT_W        = $clog2(COLS * PAGES);
    localparam int IDLE_PCT      = 27;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 8000;
    localparam int TAIL_CYCLES   = 40;
    localparam int PHASES        = 9;
    localparam int PAD_W         = TDATA_W - BYTE_W - PAGE_W - COLUMN_W;

    typedef enum logic [1:0] {
        ENTRY_REQ,
        ENTRY_CFG,
        ENTRY_DRAIN
    } t_entry_kind;

    typedef struct packed {
        t_entry_kind           kind;
        t_cmd                  cmd;
        logic [COLUMN_W-1:0]   column;
        logic [PAGE_W-1:0]     page;
        logic [BYTE_W-1:0]     wbyte;
        logic [CFG_ADDR_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
    } t_entry;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [TDATA_W-1:0]    s_axis_tdata  = '0;
    logic [TUSER_W-1:0]    s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [BYTE_W-1:0]     m_axis_tdata;

    // local copy of the block state
    logic [BYTE_W-1:0]      shadow_pixels [COLS*PAGES];
    int unsigned            shadow_col;
    int unsigned            shadow_page;
    logic [COLS_REG_W-1:0]  shadow_col_count;
    logic [PAGES_REG_W-1:0] shadow_page_count;

    t_entry            pending [$];
    t_entry            cur_req;
    logic [BYTE_W-1:0] read_bytes_due [$];
    int unsigned       reads_due_total = 0;
    int unsigned       reads_seen      = 0;
    int unsigned       req_count       = 0;
    int unsigned       clear_count     = 0;
    int unsigned       reg_writes      = 0;
    int unsigned       mismatches      = 0;
    int unsigned       idle_run        = 0;
    int unsigned       stall_cycles    = 0;
    logic              calm_stretch    = 1'b0;

    page_addressed_display_ram u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int unsigned cols_in_use();
        if (shadow_col_count == 0 || shadow_col_count > COLS)
            return COLS;
        return 32'(shadow_col_count);
    endfunction

    // advance the pixel store and pointers by one request, queue any read byte
    task automatic predict_display_ram(input t_entry e);
        logic [SLOT_W-1:0] slot;
        int unsigned       pg_mod;
        slot = SLOT_W'((shadow_page % PAGES) * COLS + (shadow_col % COLS));
        case (e.cmd)
            CMD_SET_POS: begin
                pg_mod = (shadow_page_count == 0 || shadow_page_count > PAGES) ?
                         PAGES : 32'(shadow_page_count);
                shadow_col  = e.column % cols_in_use();
                shadow_page = e.page % pg_mod;
            end
            CMD_WRITE: begin
                shadow_pixels[slot] = e.wbyte;
                shadow_col = (shadow_col + 1) % cols_in_use();
            end
            CMD_READ: begin
                read_bytes_due.push_back(shadow_pixels[slot]);
                reads_due_total++;
                shadow_col = (shadow_col + 1) % cols_in_use();
            end
            default: begin
                // pointers survive a clear
                foreach (shadow_pixels[i]) shadow_pixels[i] = '0;
                clear_count++;
            end
        endcase
    endtask

    task automatic add_req(input t_cmd cmd, input logic [COLUMN_W-1:0] column,
                           input logic [PAGE_W-1:0] page, input logic [BYTE_W-1:0] wbyte);
        t_entry e;
        e = '0;
        e.kind   = ENTRY_REQ;
        e.cmd    = cmd;
        e.column = column;
        e.page   = page;
        e.wbyte  = wbyte;
        pending.push_back(e);
    endtask

    task automatic add_cfg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        t_entry e;
        e = '0;
        e.kind    = ENTRY_CFG;
        e.reg_idx = idx;
        e.reg_val = val;
        pending.push_back(e);
    endtask

    task automatic add_drain();
        t_entry e;
        e = '0;
        e.kind = ENTRY_DRAIN;
        pending.push_back(e);
    endtask

    // mostly write runs read back from the same position, plus noise and clears
    task automatic add_traffic(input int unsigned n);
        int unsigned queued;
        int unsigned run;
        int unsigned roll;
        logic [COLUMN_W-1:0] c;
        logic [PAGE_W-1:0]   p;
        queued = 0;
        while (queued < n) begin
            roll = $urandom_range(0, 99);
            c = COLUMN_W'($urandom_range(0, 255));
            p = PAGE_W'($urandom_range(0, 15));
            if (roll < 66) begin
                run = $urandom_range(1, 12);
                add_req(CMD_SET_POS, c, p, BYTE_W'($urandom_range(0, 255)));
                repeat (run)
                    add_req(CMD_WRITE, COLUMN_W'($urandom_range(0, 255)),
                            PAGE_W'($urandom_range(0, 15)), BYTE_W'($urandom_range(0, 255)));
                add_req(CMD_SET_POS, c, p, BYTE_W'($urandom_range(0, 255)));
                repeat (run)
                    add_req(CMD_READ, COLUMN_W'($urandom_range(0, 255)),
                            PAGE_W'($urandom_range(0, 15)), BYTE_W'($urandom_range(0, 255)));
                queued += 2 * run + 2;
            end else if (roll == 66) begin
                // run past a full row so the column pointer wraps onto itself
                add_req(CMD_SET_POS, c, p, 8'h00);
                repeat (130) add_req(CMD_WRITE, 8'h00, 4'h0, BYTE_W'($urandom_range(0, 255)));
                add_req(CMD_SET_POS, c, p, 8'h00);
                repeat (3) add_req(CMD_READ, 8'h00, 4'h0, 8'h00);
                queued += 135;
            end else if (roll < 69) begin
                add_req(CMD_CLEAR, c, p, BYTE_W'($urandom_range(0, 255)));
                queued++;
            end else begin
                add_req(t_cmd'($urandom_range(0, 2)), c, p, BYTE_W'($urandom_range(0, 255)));
                queued++;
            end
        end
    endtask

    always @(posedge i_clk) begin : drive_requests
        t_entry head;
        logic   took;
        logic   valid_n;
        logic   we_n;
        took    = s_axis_tvalid && s_axis_tready;
        valid_n = s_axis_tvalid && !took;
        we_n    = 1'b0;
        if (!i_rst_n) begin
            valid_n  = 1'b0;
            idle_run = 0;
        end else begin
            if (took) begin
                predict_display_ram(cur_req);
                req_count++;
            end
            if (took || !s_axis_tready)
                idle_run = 0;
            else if (idle_run < SETTLE_CYCLES)
                idle_run++;
            if (!valid_n && pending.size() != 0) begin
                head = pending[0];
                case (head.kind)
                    ENTRY_REQ: begin
                        if (calm_stretch || $urandom_range(0, 99) >= IDLE_PCT) begin
                            void'(pending.pop_front());
                            cur_req = head;
                            valid_n = 1'b1;
                        end
                    end
                    ENTRY_CFG: begin
                        // only once the block has gone quiet
                        if (reads_seen == reads_due_total && idle_run >= SETTLE_CYCLES) begin
                            void'(pending.pop_front());
                            we_n = 1'b1;
                            i_cfg_addr  <= head.reg_idx;
                            i_cfg_wdata <= head.reg_val;
                            if (head.reg_idx == REG_COLUMN_COUNT)
                                shadow_col_count = head.reg_val;
                            else
                                shadow_page_count = head.reg_val[PAGES_REG_W-1:0];
                            reg_writes++;
                        end
                    end
                    default: begin
                        if (reads_seen == reads_due_total)
                            void'(pending.pop_front());
                    end
                endcase
            end
        end
        s_axis_tvalid <= valid_n;
        i_cfg_we      <= we_n;
        if (valid_n) begin
            s_axis_tdata <= {{PAD_W{1'b0}}, cur_req.wbyte, cur_req.page, cur_req.column};
            s_axis_tuser <= cur_req.cmd;
        end
        calm_stretch <= (req_count >= 500 && req_count < 750);
    end

    always @(posedge i_clk) begin : check_results
        logic [BYTE_W-1:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (read_bytes_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: read byte %02h with no read request pending",
                             $realtime, m_axis_tdata);
            end else begin
                want = read_bytes_due.pop_front();
                reads_seen <= reads_seen + 1;
                if (m_axis_tdata !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: read_byte expected %02h got %02h",
                                 $realtime, want, m_axis_tdata);
                end
            end
        end
        m_axis_tready <= calm_stretch || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("no request moved for %0d cycles", STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int unsigned phase_cols [PHASES];
        int unsigned phase_pages [PHASES];
        phase_cols  = '{128, 1, 0, 200, 5, 127, 17, 128, 0};
        phase_pages = '{8, 1, 0, 8'hF3, 12, 7, 8'h52, 9, 0};
        phase_cols[PHASES-1]  = $urandom_range(0, 255);
        phase_pages[PHASES-1] = $urandom_range(0, 255);

        foreach (shadow_pixels[i]) shadow_pixels[i] = '0;
        shadow_col        = 0;
        shadow_page       = 0;
        shadow_col_count  = COLUMN_COUNT_RST;
        shadow_page_count = PAGE_COUNT_RST;

        // store is cleared by reset
        add_req(CMD_READ, 8'h00, 4'h0, 8'h00);
        // out-of-range position folds into the last column and page
        add_req(CMD_SET_POS, 8'hFF, 4'hF, 8'h00);
        add_req(CMD_WRITE, 8'h00, 4'h0, 8'hFF);
        add_req(CMD_WRITE, 8'h00, 4'h0, 8'h01);
        add_req(CMD_WRITE, 8'h00, 4'h0, 8'h80);
        add_req(CMD_SET_POS, 8'd127, 4'd7, 8'h00);
        repeat (4) add_req(CMD_READ, 8'h00, 4'h0, 8'h00);
        // unused fields must be ignored
        add_req(CMD_SET_POS, 8'h00, 4'h0, 8'hAA);
        add_req(CMD_WRITE, 8'hFF, 4'hF, 8'h55);
        add_req(CMD_CLEAR, 8'h5A, 4'h9, 8'hC3);
        // clear keeps the pointers where they were
        add_req(CMD_WRITE, 8'h00, 4'h0, 8'h77);
        add_req(CMD_SET_POS, 8'd1, 4'd0, 8'hFF);
        add_req(CMD_READ, 8'hFF, 4'hF, 8'hFF);
        // counts lowered below the pointers
        add_req(CMD_SET_POS, 8'd100, 4'd3, 8'h00);
        add_cfg(REG_COLUMN_COUNT, 8'd10);
        add_cfg(REG_PAGE_COUNT, 8'd2);
        add_req(CMD_WRITE, 8'h00, 4'h0, 8'h3C);
        add_req(CMD_READ, 8'h00, 4'h0, 8'h00);
        add_cfg(REG_COLUMN_COUNT, 8'd128);
        add_cfg(REG_PAGE_COUNT, 8'd8);
        add_req(CMD_SET_POS, 8'd100, 4'd3, 8'h00);
        add_req(CMD_READ, 8'h00, 4'h0, 8'h00);
        // single column, single page
        add_cfg(REG_COLUMN_COUNT, 8'd1);
        add_cfg(REG_PAGE_COUNT, 8'd1);
        add_req(CMD_SET_POS, 8'd200, 4'd9, 8'h00);
        add_req(CMD_WRITE, 8'h00, 4'h0, 8'h5A);
        add_req(CMD_WRITE, 8'h00, 4'h0, 8'hA5);
        add_req(CMD_READ, 8'h00, 4'h0, 8'h00);
        add_drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            add_cfg(REG_COLUMN_COUNT, CFG_DATA_W'(phase_cols[ph]));
            add_cfg(REG_PAGE_COUNT, CFG_DATA_W'(phase_pages[ph]));
            add_traffic(75);
            if (ph % 3 == 1)
                add_drain();
            add_traffic(75);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (pending.size() != 0 || s_axis_tvalid || reads_seen != reads_due_total);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (read_bytes_due.size() != 0) begin
            mismatches++;
            $display("%0d read bytes never came out", read_bytes_due.size());
        end
        $display("covered %0d requests: %0d read bytes checked, %0d full clears",
                 req_count, reads_due_total, clear_count);
        $display("%0d register writes over %0d column/page settings incl. out-of-range counts",
                 reg_writes, PHASES + 3);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("simulation failed");
        end
        $finish;
    end

endmodule
